// ===== rtl/rrts_pkg.sv =====
package rrts_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int ID_BITS_DEF   = 8;
    localparam int TIME_BITS_DEF = 32;
    localparam int SPAN_BITS     = 32;
    localparam int QTM_BITS      = 16;

    localparam logic [QTM_BITS-1:0]  QUANTUM_RESET = 16'd10;
    localparam logic [SPAN_BITS-1:0] SMAX_RESET    = 32'hFFFF_FFFF;

    typedef enum logic [0:0] {
        CFG_QUANTUM = 1'b0,
        CFG_SMAX    = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        TS_READY    = 2'd0,
        TS_RUNNING  = 2'd1,
        TS_SLEEPING = 2'd2,
        TS_BLOCKED  = 2'd3
    } task_st_t;

    typedef enum logic [2:0] {
        EV_ADD   = 3'd0,
        EV_WAKE  = 3'd1,
        EV_TICK  = 3'd2,
        EV_YIELD = 3'd3,
        EV_SLEEP = 3'd4,
        EV_BLOCK = 3'd5,
        EV_EXIT  = 3'd6
    } ev_kind_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_NONE_RUN  = 3'd1,
        STS_DUP       = 3'd2,
        STS_FULL      = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_WRONG_ST  = 3'd5,
        STS_TOO_LONG  = 3'd6,
        STS_BAD_REC   = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_SEL,
        S_DONE
    } seq_state_t;

    // per-field write enables of the slot memory
    typedef struct packed {
        logic st;
        logic id;
        logic rec;
    } slot_wen_t;

endpackage

// ===== rtl/rrts_slot_mem.sv =====
module rrts_slot_mem #(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32,
    localparam int IDX_BITS = $clog2(SLOTS)
) (
    input  logic                     clk,
    input  rrts_pkg::slot_wen_t      wen,
    input  logic [IDX_BITS-1:0]      waddr,
    input  rrts_pkg::task_st_t       wstate,
    input  logic [ID_BITS-1:0]       wid,
    input  logic [TIME_BITS-1:0]     wstart,
    input  logic [rrts_pkg::SPAN_BITS-1:0] wspan,
    input  logic [IDX_BITS-1:0]      raddr,
    output rrts_pkg::task_st_t       rd_state,
    output logic [ID_BITS-1:0]       rd_id,
    output logic [TIME_BITS-1:0]     rd_start,
    output logic [rrts_pkg::SPAN_BITS-1:0] rd_span
);
    import rrts_pkg::*;

    task_st_t               st_mem    [SLOTS];
    logic [ID_BITS-1:0]     id_mem    [SLOTS];
    logic [TIME_BITS-1:0]   start_mem [SLOTS];
    logic [SPAN_BITS-1:0]   span_mem  [SLOTS];

    task_st_t               rd_state_reg;
    logic [ID_BITS-1:0]     rd_id_reg;
    logic [TIME_BITS-1:0]   rd_start_reg;
    logic [SPAN_BITS-1:0]   rd_span_reg;

    always_ff @(posedge clk)
    begin
        if (wen.st)
        begin
            st_mem[waddr] <= wstate;
        end
        if (wen.id)
        begin
            id_mem[waddr] <= wid;
        end
        if (wen.rec)
        begin
            start_mem[waddr] <= wstart;
            span_mem[waddr]  <= wspan;
        end
        rd_state_reg <= st_mem[raddr];
        rd_id_reg    <= id_mem[raddr];
        rd_start_reg <= start_mem[raddr];
        rd_span_reg  <= span_mem[raddr];
    end

    assign rd_state = rd_state_reg;
    assign rd_id    = rd_id_reg;
    assign rd_start = rd_start_reg;
    assign rd_span  = rd_span_reg;

endmodule

// ===== rtl/rrts_ctrl.sv =====
module rrts_ctrl #(
    parameter int SLOTS     = 16,
    parameter int ID_BITS   = 8,
    parameter int TIME_BITS = 32,
    localparam int IDX_BITS = $clog2(SLOTS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2:0]               kind,
    input  logic [7:0]               task_id,
    input  logic [31:0]              now_time,
    input  logic [31:0]              sleep_length,
    input  logic [rrts_pkg::QTM_BITS-1:0]  quantum,
    input  logic [rrts_pkg::SPAN_BITS-1:0] smax,
    output logic                     busy,
    output logic                     done,
    output logic [2:0]               status,
    output logic [IDX_BITS-1:0]      slot_index,
    output logic                     running_valid,
    output logic [7:0]               running_id,
    output logic                     switched,
    // slot memory
    output rrts_pkg::slot_wen_t      m_wen,
    output logic [IDX_BITS-1:0]      m_waddr,
    output rrts_pkg::task_st_t       m_wstate,
    output logic [ID_BITS-1:0]       m_wid,
    output logic [TIME_BITS-1:0]     m_wstart,
    output logic [rrts_pkg::SPAN_BITS-1:0] m_wspan,
    output logic [IDX_BITS-1:0]      m_raddr,
    input  rrts_pkg::task_st_t       m_rstate,
    input  logic [ID_BITS-1:0]       m_rid,
    input  logic [TIME_BITS-1:0]     m_rstart,
    input  logic [rrts_pkg::SPAN_BITS-1:0] m_rspan
);
    import rrts_pkg::*;

    localparam int CNT_BITS = $clog2(SLOTS + 1);
    localparam int CW       = (TIME_BITS > SPAN_BITS) ? TIME_BITS : SPAN_BITS;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(SLOTS - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(SLOTS);

    seq_state_t state_reg, state_next;

    ev_kind_t               kind_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [SPAN_BITS-1:0]   len_reg;

    logic [SLOTS-1:0]       used_reg, used_next;
    logic [CNT_BITS-1:0]    ucnt_reg, ucnt_next;
    logic                   run_reg, run_next;
    logic [IDX_BITS-1:0]    rslot_reg, rslot_next;
    logic [ID_BITS-1:0]     rid_reg, rid_next;
    logic [IDX_BITS-1:0]    rot_reg, rot_next;
    logic [QTM_BITS-1:0]    qc_reg, qc_next;

    // scan walk
    logic [IDX_BITS-1:0]    idx_reg, idx_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   pv_reg, pv_next;
    logic [IDX_BITS-1:0]    pidx_reg, pidx_next;
    logic                   pused_reg, pused_next;
    logic                   hit_reg, hit_next;
    logic [IDX_BITS-1:0]    hidx_reg, hidx_next;
    task_st_t               hst_reg, hst_next;
    logic                   free_reg, free_next;
    logic [IDX_BITS-1:0]    fidx_reg, fidx_next;
    logic                   bad_reg, bad_next;

    status_t                sts_reg, sts_next;
    logic [IDX_BITS-1:0]    sout_reg, sout_next;
    logic                   sw_reg, sw_next;

    logic                   accept;
    logic                   walk_end;
    logic                   sel_found;
    logic                   issue;
    logic [TIME_BITS-1:0]   elapsed;
    logic [CW-1:0]          el_w, span_w;
    logic [QTM_BITS-1:0]    q_inc;
    logic                   long_sleep;

    assign accept   = start && (state_reg == S_IDLE);
    assign walk_end = (cnt_reg == CNT_FULL) && !pv_reg;
    assign issue    = (cnt_reg != CNT_FULL);

    assign elapsed    = now_reg - m_rstart;
    assign el_w       = CW'(elapsed);
    assign span_w     = CW'(m_rspan);
    assign q_inc      = qc_reg + QTM_BITS'(1);
    assign long_sleep = len_reg > smax;
    assign sel_found  = (state_reg == S_SEL) && pv_reg && pused_reg
                        && (m_rstate == TS_READY);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind == EV_ADD || kind == EV_WAKE || kind == EV_TICK)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_ACT;
                    end
                end
            end
            S_SCAN:
            begin
                if (walk_end)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = run_next ? S_DONE : S_SEL;
            end
            S_SEL:
            begin
                if (sel_found || walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory access
    always_comb
    begin
        used_next  = used_reg;
        ucnt_next  = ucnt_reg;
        run_next   = run_reg;
        rslot_next = rslot_reg;
        rid_next   = rid_reg;
        rot_next   = rot_reg;
        qc_next    = qc_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        pv_next    = 1'b0;
        pidx_next  = idx_reg;
        pused_next = used_reg[idx_reg];
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        hst_next   = hst_reg;
        free_next  = free_reg;
        fidx_next  = fidx_reg;
        bad_next   = bad_reg;
        sts_next   = sts_reg;
        sout_next  = sout_reg;
        sw_next    = sw_reg;

        m_wen    = '0;
        m_waddr  = pidx_reg;
        m_wstate = TS_READY;
        m_wid    = id_reg;
        m_wstart = now_reg;
        m_wspan  = len_reg;
        m_raddr  = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                idx_next  = '0;
                cnt_next  = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                bad_next  = 1'b0;
                sts_next  = STS_OK;
                sout_next = '0;
                sw_next   = 1'b0;
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + CNT_BITS'(1);
                    idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_BITS'(1);
                end
                if (pv_reg)
                begin
                    if (pused_reg)
                    begin
                        if (m_rid == id_reg && !hit_reg)
                        begin
                            hit_next  = 1'b1;
                            hidx_next = pidx_reg;
                            hst_next  = m_rstate;
                        end
                        if (kind_reg == EV_TICK && m_rstate == TS_SLEEPING)
                        begin
                            if (m_rspan == '0 || m_rspan > smax)
                            begin
                                bad_next = 1'b1;
                            end
                            else if (el_w >= span_w)
                            begin
                                m_wen.st = 1'b1;
                                m_wstate = TS_READY;
                            end
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next = 1'b1;
                        fidx_next = pidx_reg;
                    end
                end
            end
            S_ACT:
            begin
                m_waddr = rslot_reg;
                case (kind_reg)
                    EV_ADD:
                    begin
                        if (hit_reg)
                        begin
                            sts_next = STS_DUP;
                        end
                        else if (!free_reg)
                        begin
                            sts_next = STS_FULL;
                        end
                        else
                        begin
                            m_waddr  = fidx_reg;
                            m_wen.st = 1'b1;
                            m_wen.id = 1'b1;
                            m_wstate = TS_READY;
                            used_next[fidx_reg] = 1'b1;
                            ucnt_next = ucnt_reg + CNT_BITS'(1);
                            sout_next = fidx_reg;
                        end
                    end
                    EV_WAKE:
                    begin
                        if (!hit_reg)
                        begin
                            sts_next = STS_NOT_FOUND;
                        end
                        else if (hst_reg != TS_BLOCKED)
                        begin
                            sts_next = STS_WRONG_ST;
                        end
                        else
                        begin
                            m_waddr   = hidx_reg;
                            m_wen.st  = 1'b1;
                            m_wstate  = TS_READY;
                            sout_next = hidx_reg;
                        end
                    end
                    EV_TICK:
                    begin
                        sts_next = bad_reg ? STS_BAD_REC : STS_OK;
                        if (run_reg)
                        begin
                            if (q_inc >= quantum)
                            begin
                                qc_next  = '0;
                                m_wen.st = 1'b1;
                                m_wstate = TS_READY;
                                run_next = 1'b0;
                            end
                            else
                            begin
                                qc_next = q_inc;
                            end
                        end
                    end
                    EV_YIELD, EV_BLOCK:
                    begin
                        if (!run_reg)
                        begin
                            sts_next = STS_NONE_RUN;
                        end
                        else
                        begin
                            m_wen.st = 1'b1;
                            m_wstate = (kind_reg == EV_YIELD) ? TS_READY : TS_BLOCKED;
                            run_next = 1'b0;
                        end
                    end
                    EV_SLEEP:
                    begin
                        if (!run_reg)
                        begin
                            sts_next = STS_NONE_RUN;
                        end
                        else if (long_sleep)
                        begin
                            sts_next = STS_TOO_LONG;
                        end
                        else if (len_reg != '0)
                        begin
                            m_wen.st  = 1'b1;
                            m_wen.rec = 1'b1;
                            m_wstate  = TS_SLEEPING;
                            run_next  = 1'b0;
                        end
                    end
                    EV_EXIT:
                    begin
                        if (!run_reg)
                        begin
                            sts_next = STS_NONE_RUN;
                        end
                        else
                        begin
                            used_next[rslot_reg] = 1'b0;
                            ucnt_next = ucnt_reg - CNT_BITS'(1);
                            if (ucnt_reg == CNT_BITS'(1))
                            begin
                                rot_next = '0;
                            end
                            run_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        sts_next = STS_OK;
                    end
                endcase
                // selection walk starts at the rotating index
                idx_next = rot_next;
                cnt_next = '0;
            end
            S_SEL:
            begin
                if (issue)
                begin
                    pv_next  = 1'b1;
                    cnt_next = cnt_reg + CNT_BITS'(1);
                    idx_next = (idx_reg == IDX_LAST) ? '0 : idx_reg + IDX_BITS'(1);
                end
                if (sel_found)
                begin
                    pv_next    = 1'b0;
                    cnt_next   = CNT_FULL;
                    m_wen.st   = 1'b1;
                    m_wstate   = TS_RUNNING;
                    run_next   = 1'b1;
                    rslot_next = pidx_reg;
                    rid_next   = m_rid;
                    rot_next   = (pidx_reg == IDX_LAST) ? '0 : pidx_reg + IDX_BITS'(1);
                    qc_next    = '0;
                    sw_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            ucnt_reg  <= '0;
            run_reg   <= 1'b0;
            rslot_reg <= '0;
            rid_reg   <= '0;
            rot_reg   <= '0;
            qc_reg    <= '0;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            pv_reg    <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            sts_reg   <= STS_OK;
            sout_reg  <= '0;
            sw_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ucnt_reg  <= ucnt_next;
            run_reg   <= run_next;
            rslot_reg <= rslot_next;
            rid_reg   <= rid_next;
            rot_reg   <= rot_next;
            qc_reg    <= qc_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            pv_reg    <= pv_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            bad_reg   <= bad_next;
            sts_reg   <= sts_next;
            sout_reg  <= sout_next;
            sw_reg    <= sw_next;
        end
    end

    // beat payload and walk side data, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= ev_kind_t'(kind);
            id_reg   <= ID_BITS'(task_id);
            now_reg  <= TIME_BITS'(now_time);
            len_reg  <= sleep_length;
        end
        pidx_reg  <= pidx_next;
        pused_reg <= pused_next;
        hidx_reg  <= hidx_next;
        hst_reg   <= hst_next;
        fidx_reg  <= fidx_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = (state_reg == S_DONE);
    assign status        = sts_reg;
    assign slot_index    = sout_reg;
    assign running_valid = run_reg;
    assign running_id    = run_reg ? 8'(rid_reg) : 8'd0;
    assign switched      = sw_reg;

endmodule

// ===== rtl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler: one result beat per event, shown on done for one cycle.
// Add, wake and tick first walk the table for the id and for sleep wakeups; every event is
// then applied, and if no task is left running a selection walk picks the next ready task
// before the done beat. One event at a time; slot RAM port.
// The receiver cannot stall; busy stays high until the done beat.
// Reset (async, rst_n low): empty table, nothing running, config at reset values.
module round_robin_task_scheduler #(
    parameter int SLOTS     = rrts_pkg::SLOTS_DEF,
    parameter int ID_BITS   = rrts_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = rrts_pkg::TIME_BITS_DEF,
    localparam int IDX_BITS = $clog2(SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    // event command
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          kind,
    input  logic [7:0]          task_id,
    input  logic [31:0]         now_time,
    input  logic [31:0]         sleep_length,
    // result beat
    output logic                done,
    output logic [2:0]          status,
    output logic [IDX_BITS-1:0] slot_index,
    output logic                running_valid,
    output logic [7:0]          running_id,
    output logic                switched,
    // config writes
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import rrts_pkg::*;

    logic [QTM_BITS-1:0]  quantum_reg;
    logic [SPAN_BITS-1:0] smax_reg;

    slot_wen_t              m_wen;
    logic [IDX_BITS-1:0]    m_waddr;
    task_st_t               m_wstate;
    logic [ID_BITS-1:0]     m_wid;
    logic [TIME_BITS-1:0]   m_wstart;
    logic [SPAN_BITS-1:0]   m_wspan;
    logic [IDX_BITS-1:0]    m_raddr;
    task_st_t               m_rstate;
    logic [ID_BITS-1:0]     m_rid;
    logic [TIME_BITS-1:0]   m_rstart;
    logic [SPAN_BITS-1:0]   m_rspan;

    // Config registers; only to be written while idle, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
            smax_reg    <= SMAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_QUANTUM: quantum_reg <= cfg_data[QTM_BITS-1:0];
                CFG_SMAX:    smax_reg    <= cfg_data;
                default:     smax_reg    <= smax_reg;
            endcase
        end
    end

    // Slot table: state, id and sleep record per slot, one read and one write a cycle.
    // The used bits live in flops inside the sequencer so reset empties the table at once.
    rrts_slot_mem #(
        .SLOTS     (SLOTS),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_mem (
        .clk      (clk),
        .wen      (m_wen),
        .waddr    (m_waddr),
        .wstate   (m_wstate),
        .wid      (m_wid),
        .wstart   (m_wstart),
        .wspan    (m_wspan),
        .raddr    (m_raddr),
        .rd_state (m_rstate),
        .rd_id    (m_rid),
        .rd_start (m_rstart),
        .rd_span  (m_rspan)
    );

    // Sequencer: walks the table once for id lookup / sleep wakeups (one slot a cycle,
    // write-back in the cycle after the read), applies the event, then, if no task is
    // left running, walks from the rotating start to pick the next ready task.
    rrts_ctrl #(
        .SLOTS     (SLOTS),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .task_id       (task_id),
        .now_time      (now_time),
        .sleep_length  (sleep_length),
        .quantum       (quantum_reg),
        .smax          (smax_reg),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .slot_index    (slot_index),
        .running_valid (running_valid),
        .running_id    (running_id),
        .switched      (switched),
        .m_wen         (m_wen),
        .m_waddr       (m_waddr),
        .m_wstate      (m_wstate),
        .m_wid         (m_wid),
        .m_wstart      (m_wstart),
        .m_wspan       (m_wspan),
        .m_raddr       (m_raddr),
        .m_rstate      (m_rstate),
        .m_rid         (m_rid),
        .m_rstart      (m_rstart),
        .m_rspan       (m_rspan)
    );

`ifndef ASSERT_OFF
    // a done beat only comes out of a busy event
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without an event in flight");

    // an accepted event keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not raise busy");

    // after the done beat the block is free again
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after done beat");

    // a switch always leaves a task running
    a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (done && switched) |-> running_valid)
        else $error("switched with no running task");
`endif

endmodule
